@@ design/sum_addsum_frame_receiver_assert.svh @@
// assertion macros used by the frame receiver checker
// every macro samples on clk and is disabled while rst_n is low
`ifndef SUM_ADDSUM_FRAME_RECEIVER_ASSERT_SVH
`define SUM_ADDSUM_FRAME_RECEIVER_ASSERT_SVH

// condition must hold at every clock edge
`define SAF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SAF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/saf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_pkg
// shared constants and types of the sum / sum-of-sums frame receiver
// ----------------------------------------------------------------------------
package saf_pkg;

    localparam logic [7:0] HDR0       = 8'hAA;
    localparam logic [7:0] HDR1       = 8'hFF;
    localparam logic [7:0] TYPE_RESET = 8'h01;

    // parser phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CK1  = 3'd5;
    localparam logic [2:0] PH_CK2  = 3'd6;

    // result status codes
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_PAYLOAD  = 2'd1;
    localparam logic [1:0] ST_ACCEPTED = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] running_sum;
        logic [7:0] sum_of_sums;
        logic [7:0] payload_length;
        logic [7:0] payload_count;
        logic [7:0] current_type;
        logic       first_check_ok;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic [7:0] byte_offset;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
    } result_t;

endpackage

@@ design/saf_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_parser
// next-state and result logic of the frame parser for one received byte
// ----------------------------------------------------------------------------
module saf_parser
(
    input  saf_pkg::parse_state_t cur_state,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            expected_type,
    output saf_pkg::parse_state_t next_state,
    output saf_pkg::result_t      result
);
    import saf_pkg::*;

    logic [7:0] acc_rs;
    logic [7:0] acc_ss;
    logic [7:0] count_inc;
    logic [1:0] status;

    assign acc_rs    = cur_state.running_sum + rx_byte;
    assign acc_ss    = cur_state.sum_of_sums + acc_rs;
    assign count_inc = cur_state.payload_count + 8'd1;

    always_comb
    begin
        next_state = cur_state;
        status     = ST_NONE;
        result     = '0;

        unique case (cur_state.phase)
            PH_HDR1:
            begin
                priority if (rx_byte == HDR1)
                begin
                    next_state.running_sum = acc_rs;
                    next_state.sum_of_sums = acc_ss;
                    next_state.phase       = PH_TYPE;
                end
                else if (rx_byte == HDR0)
                begin
                    // sums restart with the new first header byte
                    next_state.running_sum = HDR0;
                    next_state.sum_of_sums = HDR0;
                    next_state.phase       = PH_HDR1;
                end
                else
                begin
                    next_state.phase = PH_HUNT;
                end
            end
            PH_TYPE:
            begin
                // a type match wins over re-arming on the header byte
                priority if (rx_byte == expected_type)
                begin
                    next_state.running_sum  = acc_rs;
                    next_state.sum_of_sums  = acc_ss;
                    next_state.current_type = rx_byte;
                    next_state.phase        = PH_LEN;
                end
                else if (rx_byte == HDR0)
                begin
                    next_state.running_sum = HDR0;
                    next_state.sum_of_sums = HDR0;
                    next_state.phase       = PH_HDR1;
                end
                else
                begin
                    next_state.phase = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                next_state.running_sum    = acc_rs;
                next_state.sum_of_sums    = acc_ss;
                next_state.payload_length = rx_byte;
                next_state.payload_count  = '0;
                next_state.phase          = (rx_byte == 8'd0) ? PH_CK1 : PH_DATA;
            end
            PH_DATA:
            begin
                next_state.running_sum   = acc_rs;
                next_state.sum_of_sums   = acc_ss;
                next_state.payload_count = count_inc;
                if (count_inc == cur_state.payload_length)
                begin
                    next_state.phase = PH_CK1;
                end
                status             = ST_PAYLOAD;
                result.data_byte   = rx_byte;
                result.byte_offset = cur_state.payload_count;
            end
            PH_CK1:
            begin
                next_state.first_check_ok = (rx_byte == cur_state.running_sum);
                next_state.phase          = PH_CK2;
            end
            PH_CK2:
            begin
                status = (cur_state.first_check_ok && (rx_byte == cur_state.sum_of_sums))
                         ? ST_ACCEPTED : ST_REJECTED;
                next_state.phase = PH_HUNT;
            end
            default:
            begin
                // hunting, and the unused phase code behaves the same
                if (rx_byte == HDR0)
                begin
                    next_state.running_sum = HDR0;
                    next_state.sum_of_sums = HDR0;
                    next_state.phase       = PH_HDR1;
                end
                else
                begin
                    next_state.phase = PH_HUNT;
                end
            end
        endcase

        result.status = status;
        if (status != ST_NONE)
        begin
            result.frame_type   = cur_state.current_type;
            result.frame_length = cur_state.payload_length;
        end
    end

endmodule

@@ design/sum_addsum_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_addsum_frame_receiver
// byte-stream frame receiver with 8-bit sum and sum-of-sums check
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry rx_byte, one received byte per item
//   output channel: out_valid / out_stall carry exactly one result item per
//   input item: status, data_byte, byte_offset, frame_type, frame_length
//   config: cfg_wr_en writes cfg_wr_data into the expected frame type; write
//   only while no item is in flight
//   path: an accepted byte enters the input register; its result is then
//   registered in the result register, from which it is offered
//   throughput: one item per cycle while no stall holds the result register,
//   set by the combinational parser step between the input register and the
//   result register
//   stall: when out_stall holds a full result register, the input register
//   holds too and in_stall rises once it carries an item; nothing is dropped
//   reset: parser returns to header hunting with cleared sums, the expected
//   type returns to 0x01, both registers empty
// ----------------------------------------------------------------------------
module sum_addsum_frame_receiver
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] data_byte,
    output logic [7:0] byte_offset,
    output logic [7:0] frame_type,
    output logic [7:0] frame_length
);
    import saf_pkg::*;

    logic [7:0]   exp_type_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_reg;
    result_t      result_next;
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         load_in;

    // result register can take a new item
    assign advance       = !out_valid_reg || !out_stall;
    assign in_stall      = in_valid_reg && !advance;
    assign load_in       = in_valid && !in_stall;
    assign in_valid_next = load_in || (in_valid_reg && !advance);

    saf_parser u_parser
    (
        .cur_state     (state_reg),
        .rx_byte       (in_byte_reg),
        .expected_type (exp_type_reg),
        .next_state    (state_next),
        .result        (result_next)
    );

    // expected frame type register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_type_reg <= TYPE_RESET;
        end
        else if (cfg_wr_en)
        begin
            exp_type_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // all-zero state is header hunting with cleared sums
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign data_byte    = result_reg.data_byte;
    assign byte_offset  = result_reg.byte_offset;
    assign frame_type   = result_reg.frame_type;
    assign frame_length = result_reg.frame_length;

endmodule

@@ design/saf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_checker
// port-level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "sum_addsum_frame_receiver_assert.svh"

module saf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [7:0] data_byte,
    input logic [7:0] byte_offset,
    input logic [7:0] frame_length
);
    import saf_pkg::*;

    // a held result stays offered
    `SAF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

    // the input side only stalls when a result is held back
    `SAF_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without backpressure")

    // payload offsets stay inside the announced length
    `SAF_ASSERT_IMPLY(a_offset_range, out_valid && (status == ST_PAYLOAD),
        byte_offset < frame_length, "payload offset beyond frame length")

    // items without payload carry zero data fields
    `SAF_ASSERT_IMPLY(a_idle_fields, out_valid && (status != ST_PAYLOAD),
        (data_byte == 8'd0) && (byte_offset == 8'd0), "data fields set without payload")

    // a stalled result item keeps its fields
    `SAF_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(status) && $stable(data_byte) && $stable(byte_offset) && $stable(frame_length), "result changed under stall")

endmodule

bind sum_addsum_frame_receiver saf_checker u_saf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .data_byte    (data_byte),
    .byte_offset  (byte_offset),
    .frame_length (frame_length)
);

@@ tb/tb_sum_addsum_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sum_addsum_frame_receiver
// feeds byte streams of good, corrupted, truncated and noisy frames through the
// receiver and checks every result item against a cycle-free parser model,
// across several expected types and idle/stall patterns
// ----------------------------------------------------------------------------
module tb_sum_addsum_frame_receiver;

    import saf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 65;

    // check byte corruption, bit mask
    localparam int CK_GOOD     = 0;
    localparam int CK_BAD_SUM  = 1;
    localparam int CK_BAD_SOS  = 2;
    localparam int CK_BAD_BOTH = 3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [7:0] byte_offset;
    logic [7:0] frame_type;
    logic [7:0] frame_length;

    sum_addsum_frame_receiver dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .data_byte    (data_byte),
        .byte_offset  (byte_offset),
        .frame_type   (frame_type),
        .frame_length (frame_length)
    );

    always #5 clk = ~clk;

    logic [7:0] rx_bytes_pending[$];
    result_t    results_due[$];
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         hold_left = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    logic [7:0] stim_type = TYPE_RESET;

    // parser model state
    logic [7:0] trk_exp_type = TYPE_RESET;
    logic [2:0] trk_phase = PH_HUNT;
    logic [7:0] trk_sum = 8'h00;
    logic [7:0] trk_sos = 8'h00;
    logic [7:0] trk_len = 8'h00;
    logic [7:0] trk_count = 8'h00;
    logic [7:0] trk_type = 8'h00;
    logic       trk_ck1_ok = 1'b0;

    function automatic void add_to_sums(input logic [7:0] b);
        trk_sum = trk_sum + b;
        trk_sos = trk_sos + trk_sum;
    endfunction

    // a stray 0xAA starts a new frame, anything else drops back to hunting
    function automatic void resync(input logic [7:0] b);
        if (b == HDR0)
        begin
            trk_sum = 8'h00;
            trk_sos = 8'h00;
            add_to_sums(HDR0);
            trk_phase = PH_HDR1;
        end
        else
            trk_phase = PH_HUNT;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (trk_phase)
            PH_HDR1:
                if (b == HDR1)
                begin
                    add_to_sums(b);
                    trk_phase = PH_TYPE;
                end
                else
                    resync(b);
            PH_TYPE:
                if (b == trk_exp_type)
                begin
                    add_to_sums(b);
                    trk_type = b;
                    trk_phase = PH_LEN;
                end
                else
                    resync(b);
            PH_LEN:
            begin
                add_to_sums(b);
                trk_len = b;
                trk_count = 8'h00;
                trk_phase = (b == 8'h00) ? PH_CK1 : PH_DATA;
            end
            PH_DATA:
            begin
                add_to_sums(b);
                r.status = ST_PAYLOAD;
                r.data_byte = b;
                r.byte_offset = trk_count;
                trk_count = trk_count + 8'd1;
                if (trk_count == trk_len)
                    trk_phase = PH_CK1;
            end
            PH_CK1:
            begin
                trk_ck1_ok = (b == trk_sum);
                trk_phase = PH_CK2;
            end
            PH_CK2:
            begin
                r.status = (trk_ck1_ok && b == trk_sos) ? ST_ACCEPTED : ST_REJECTED;
                trk_phase = PH_HUNT;
            end
            default:
                resync(b);
        endcase
        if (r.status != ST_NONE)
        begin
            r.frame_type = trk_type;
            r.frame_length = trk_len;
        end
        return r;
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (rx_bytes_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                rx_byte <= rx_bytes_pending.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                rx_byte <= 8'($urandom);
            end
        end
    end

    // result receiver, with long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // model update and result check
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                trk_exp_type = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                got = '{status, data_byte, byte_offset, frame_type, frame_length};
                if (results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: status %0d data %02h off %0d",
                                 got.status, got.data_byte, got.byte_offset);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected st %0d data %02h off %0d type %02h",
                                      " len %0d, got st %0d data %02h off %0d type %02h len %0d"},
                                     want.status, want.data_byte, want.byte_offset,
                                     want.frame_type, want.frame_length,
                                     got.status, got.data_byte, got.byte_offset,
                                     got.frame_type, got.frame_length);
                    end
                end
            end
            if (in_valid && !in_stall)
                results_due = {results_due, parse_byte(rx_byte)};
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_frame(input logic [7:0] ftype, input int len, input int fault,
                               input bit skip_hdr0, input int cut);
        logic [7:0] fb[$];
        logic [7:0] rs;
        logic [7:0] ss;
        fb = {HDR0, HDR1, ftype, 8'(len)};
        for (int i = 0; i < len; i++)
            fb = {fb, 8'($urandom)};
        rs = 8'h00;
        ss = 8'h00;
        foreach (fb[i])
        begin
            rs = rs + fb[i];
            ss = ss + rs;
        end
        fb = {fb, (((fault & CK_BAD_SUM) != 0) ? rs ^ 8'($urandom_range(255, 1)) : rs)};
        fb = {fb, (((fault & CK_BAD_SOS) != 0) ? ss ^ 8'($urandom_range(255, 1)) : ss)};
        if (cut >= 0)
            while (fb.size() > cut)
                void'(fb.pop_back());
        foreach (fb[i])
            if (!(skip_hdr0 && i == 0))
                rx_bytes_pending = {rx_bytes_pending, fb[i]};
    endtask

    // mostly well-formed frames with random content, some broken ones and line noise
    task automatic queue_random_traffic(input int target);
        int start;
        int pick;
        int len;
        int fault;
        logic [7:0] ftype;
        start = rx_bytes_pending.size();
        while (rx_bytes_pending.size() - start < target)
        begin
            pick = $urandom_range(99);
            len = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(6);
            fault = ($urandom_range(4) == 0) ? $urandom_range(CK_BAD_BOTH, CK_BAD_SUM)
                                             : CK_GOOD;
            ftype = ($urandom_range(9) == 0) ? 8'($urandom) : stim_type;
            if (pick < 70)
                queue_frame(ftype, len, fault, 1'b0, -1);
            else if (pick < 85)
                queue_frame(ftype, len, fault, 1'b0, $urandom_range(len + 5));
            else
                repeat ($urandom_range(4, 1))
                    rx_bytes_pending = {rx_bytes_pending,
                                        (($urandom_range(2) == 0) ? HDR0 : 8'($urandom))};
        end
    endtask

    // sampled at the falling edge so the driver and monitor updates have settled
    task automatic wait_drained();
        while (rx_bytes_pending.size() > 0 || in_valid || results_due.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_type(input logic [7:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        stim_type = value;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header mismatch, type mismatch, 0xAA re-arming in both header phases
        rx_bytes_pending = {8'h00, HDR0, HDR1, 8'h07, HDR0, HDR0};
        queue_frame(TYPE_RESET, 0, CK_GOOD, 1'b1, -1);
        rx_bytes_pending = {rx_bytes_pending, HDR0, HDR1, HDR0};
        queue_frame(TYPE_RESET, 0, CK_BAD_SUM, 1'b1, -1);
        queue_frame(TYPE_RESET, 2, CK_BAD_SOS, 1'b0, -1);
        queue_frame(TYPE_RESET, 1, CK_BAD_BOTH, 1'b0, -1);
        wait_drained();

        // type equal to 0xAA must match rather than re-arm
        write_type(HDR0);
        queue_frame(HDR0, 1, CK_GOOD, 1'b0, -1);
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_type(HDR0);         send_idle_pct = 0;  stall_pct = 0;  end
                1: begin write_type(8'h00);        send_idle_pct = 83; stall_pct = 0;  end
                2: begin write_type(8'hFF);        send_idle_pct = 0;  stall_pct = 83; end
                3: begin write_type(8'($urandom)); send_idle_pct = 26; stall_pct = 26; end
                default: begin write_type(TYPE_RESET); send_idle_pct = 0; stall_pct = 0; end
            endcase
            queue_random_traffic(PHASE_BYTES);
            if (ph == 0)
            begin
                // longest payload, while the receiver holds off and the input backs up
                queue_frame(stim_type, 255, CK_GOOD, 1'b0, -1);
                hold_requests = hold_requests + 1;
            end
            wait_drained();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
